FILE: design/ezd_pkg.sv
package ezd_pkg;

    // Fraction bits of the running average (unsigned 32.16 at the default width).
    localparam int FRAC_BITS = 16;

    // Default width of the volume count.
    localparam int VOLUME_BITS_DEF = 32;

    // Quotient bits kept by the divider; anything larger saturates.
    localparam int QUO_BITS = 17;

    // Smoothing factor used when the register holds zero (0.2 in Q0.16).
    localparam logic [15:0] ALPHA_DEFAULT = 16'd13107;

    // Reset value of the threshold (2.0 in Q7.8).
    localparam logic [14:0] THRESH_RESET = 15'd512;

    // Marker size cap (10.0 in Q4.8).
    localparam logic [11:0] MARKER_CAP = 12'd2560;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTHING = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd1;

endpackage

FILE: design/ema_poisson_zscore_detector.sv
// Volume anomaly detector: exponential moving average with a Poisson-style score.
//
// Input channel (i_in_valid / o_in_ready) takes one word per sample: a volume
// count and a restart flag that seeds the average with that sample. Output
// channel (o_out_valid / i_out_ready) gives one word per input word: the gated
// score in signed Q8.8 and a marker size in Q4.8. The configuration channel
// (i_cfg_valid / o_cfg_ready) writes the smoothing factor (index 0) or the score
// threshold (index 1); it is always ready and is only to be used while idle.
//
// One word is in flight at a time. It passes through the serial average update,
// the square root (SW bits wide, where SW = (VOLUME_BITS + 17) / 2), the division
// (which ends at once when the score is too large for the divider) and the magnitude
// step. The next word is accepted only after the result of the last one has been
// loaded into the output register.
//
// Reset (synchronous, active low) clears the average and loads the default
// registers. The finished result sits in an output register, so the next word
// is accepted while the receiver stalls; a second result then waits until the
// output register is taken.
module ema_poisson_zscore_detector #(
    parameter int VOLUME_BITS = ezd_pkg::VOLUME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [VOLUME_BITS-1:0]           i_volume_count,
    input  logic                             i_restart,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [15:0]               o_gated_score,
    output logic [11:0]                      o_marker_size,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ezd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    localparam int AW = VOLUME_BITS + ezd_pkg::FRAC_BITS;
    localparam int SW = (AW + 1) / 2;
    localparam int QB = ezd_pkg::QUO_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MAG  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state;
    logic [15:0]   r_alpha;
    logic [14:0]   r_thresh;
    logic [AW-1:0] r_avg;
    logic [AW-1:0] r_vq;
    logic [AW-1:0] r_dist;
    logic          r_neg;
    logic          r_root_zero;
    logic [QB-1:0] r_mag;
    logic          r_out_valid;
    logic [15:0]   r_gated;
    logic [11:0]   r_marker;

    logic          in_fire;
    logic [AW-1:0] n_vq;
    logic [AW-1:0] n_seed;
    logic [15:0]   n_alpha;

    logic          mac_done;
    logic [AW-1:0] mac_avg;
    logic          sqrt_start;
    logic          sqrt_done;
    logic [SW-1:0] sqrt_root;
    logic          div_start;
    logic          div_done;
    logic [QB-1:0] div_quot;

    logic          out_load;
    logic          n_pass;
    logic [QB-1:0] n_lim;
    logic [QB-1:0] n_sat;
    logic [15:0]   n_gated;
    logic [11:0]   n_marker;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire = i_in_valid && o_in_ready;

    assign n_vq    = {i_volume_count, {ezd_pkg::FRAC_BITS{1'b0}}};
    assign n_seed  = i_restart ? n_vq : r_avg;
    assign n_alpha = (r_alpha == 16'd0) ? ezd_pkg::ALPHA_DEFAULT : r_alpha;

    assign sqrt_start = (r_state == S_MAC) && mac_done;
    assign div_start  = (r_state == S_SQRT) && sqrt_done;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    ezd_ema_mac #(
        .AW(AW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_fire),
        .i_alpha   (n_alpha),
        .i_sample  (n_vq),
        .i_average (n_seed),
        .o_done    (mac_done),
        .o_average (mac_avg)
    );

    ezd_isqrt #(
        .AW(AW),
        .SW(SW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (mac_avg),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    ezd_div #(
        .AW(AW),
        .SW(SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dist),
        .i_divisor  (sqrt_root),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Gating, saturation and marker size from the registered magnitude.
    // The threshold test uses the magnitude before saturation.
    always_comb begin
        n_pass   = (r_mag > QB'(r_thresh));
        n_lim    = r_neg ? QB'(32768) : QB'(32767);
        n_sat    = (r_mag > n_lim) ? n_lim : r_mag;
        n_gated  = '0;
        n_marker = '0;
        if (n_pass) begin
            n_gated = r_neg ? 16'(~n_sat + QB'(1)) : n_sat[15:0];
            if (r_mag > QB'(256)) begin
                n_marker = ezd_pkg::MARKER_CAP;
            end else begin
                n_marker = {r_mag[8:0], 3'b000} + {2'b00, r_mag[8:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= ezd_pkg::ALPHA_DEFAULT;
            r_thresh    <= ezd_pkg::THRESH_RESET;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ezd_pkg::CFG_SMOOTHING: r_alpha  <= i_cfg_data;
                    ezd_pkg::CFG_THRESHOLD: r_thresh <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_avg   <= mac_avg;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vq <= n_vq;
        end
        if (sqrt_start) begin
            r_neg  <= (r_vq < mac_avg);
            r_dist <= (r_vq >= mac_avg) ? (r_vq - mac_avg) : (mac_avg - r_vq);
        end
        if (div_start) begin
            r_root_zero <= (sqrt_root == '0);
        end
        if ((r_state == S_DIV) && div_done) begin
            // A zero average gives a zero score.
            r_mag <= r_root_zero ? '0 : div_quot;
        end
        if (out_load) begin
            r_gated  <= n_gated;
            r_marker <= n_marker;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gated_score = r_gated;
    assign o_marker_size = r_marker;

endmodule

FILE: design/ezd_ema_mac.sv
module ezd_ema_mac #(
    parameter int AW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_alpha,
    input  logic [AW-1:0] i_sample,
    input  logic [AW-1:0] i_average,
    output logic          o_done,
    output logic [AW-1:0] o_average
);

    // Computes (a*V + (65536-a)*E) >> 16 one multiplier bit per cycle, LSB first.
    // The accumulator is shifted right each step, so the dropped bits are the fraction.

    logic [AW-1:0] r_v;
    logic [AW-1:0] r_e;
    logic [AW:0]   r_ve;
    logic [AW:0]   r_acc;
    logic [15:0]   r_a;
    logic [15:0]   r_b;
    logic [3:0]    r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [AW+1:0] n_addend;
    logic [AW+1:0] n_sum;

    always_comb begin
        unique case ({r_a[0], r_b[0]})
            2'b11:   n_addend = {1'b0, r_ve};
            2'b10:   n_addend = {2'b00, r_v};
            2'b01:   n_addend = {2'b00, r_e};
            default: n_addend = '0;
        endcase
        n_sum = {1'b0, r_acc} + n_addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_sample;
            r_e   <= i_average;
            r_ve  <= {1'b0, i_sample} + {1'b0, i_average};
            r_acc <= '0;
            r_a   <= i_alpha;
            r_b   <= 16'(17'd65536 - {1'b0, i_alpha});
        end else if (r_busy) begin
            r_acc <= n_sum[AW+1:1];
            r_a   <= {1'b0, r_a[15:1]};
            r_b   <= {1'b0, r_b[15:1]};
        end
    end

    assign o_done    = r_done;
    assign o_average = r_acc[AW-1:0];

endmodule

FILE: design/ezd_isqrt.sv
module ezd_isqrt #(
    parameter int AW = 48,
    parameter int SW = (AW + 1) / 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_radicand,
    output logic          o_done,
    output logic [SW-1:0] o_root
);

    // Restoring square root, one root bit (two radicand bits) per cycle.

    localparam int RW    = 2 * SW;
    localparam int CNT_W = $clog2(SW);

    logic [RW-1:0]    r_rad;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SW+1:0] n_shift;
    logic [SW+1:0] n_trial;
    logic [SW+1:0] n_diff;
    logic          n_fit;

    always_comb begin
        n_shift = {r_rem, r_rad[RW-1:RW-2]};
        n_trial = {r_root, 2'b01};
        n_fit   = (n_shift >= n_trial);
        n_diff  = n_shift - n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RW'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RW-3:0], 2'b00};
            if (n_fit) begin
                r_rem  <= n_diff[SW-1:0];
                r_root <= {r_root[SW-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift[SW-1:0];
                r_root <= {r_root[SW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: design/ezd_div.sv
module ezd_div #(
    parameter int AW = 48,
    parameter int SW = (AW + 1) / 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [AW-1:0]              i_dividend,
    input  logic [SW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [ezd_pkg::QUO_BITS-1:0] o_quot
);

    // Restoring division producing only the low quotient bits. A quotient that
    // does not fit is found up front and returned as all ones.

    localparam int QB    = ezd_pkg::QUO_BITS;
    localparam int HW    = AW - QB;
    localparam int CW    = (HW > SW) ? HW : SW;
    localparam int CNT_W = $clog2(QB);

    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_div;
    logic [QB-1:0]    r_lo;
    logic [QB-1:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CW-1:0] n_hi;
    logic [CW-1:0] n_dvs;
    logic          n_ovf;
    logic [SW:0]   n_shift;
    logic [SW:0]   n_diff;
    logic          n_fit;

    always_comb begin
        n_hi    = CW'(i_dividend[AW-1:QB]);
        n_dvs   = CW'(i_divisor);
        n_ovf   = (n_hi >= n_dvs);
        n_shift = {r_rem, r_lo[QB-1]};
        n_diff  = n_shift - {1'b0, r_div};
        n_fit   = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (n_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(QB - 1);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= n_hi[SW-1:0];
            r_div  <= i_divisor;
            r_lo   <= i_dividend[QB-1:0];
            r_quot <= n_ovf ? '1 : '0;
        end else if (r_busy) begin
            r_lo   <= {r_lo[QB-2:0], 1'b0};
            r_quot <= {r_quot[QB-2:0], n_fit};
            r_rem  <= n_fit ? n_diff[SW-1:0] : n_shift[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
